@@ hdl/rfc3339_timestamp_parser_defines.svh @@
// Assertion macros shared by the timestamp parser RTL.
`ifndef RFC3339_TIMESTAMP_PARSER_DEFINES_SVH
`define RFC3339_TIMESTAMP_PARSER_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define RTP_ASSERT_IMP(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("rtp: same-cycle check failed");

// Next-cycle implication, checked outside reset.
`define RTP_ASSERT_NXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("rtp: next-cycle check failed");

`endif

@@ hdl/rtp_pkg.sv @@
// Types, character codes and calendar tables for the timestamp parser.
package rtp_pkg;

  // parser phases
  localparam logic [2:0] PH_DATE  = 3'd0;
  localparam logic [2:0] PH_ZONE  = 3'd1;
  localparam logic [2:0] PH_FRAC1 = 3'd2;
  localparam logic [2:0] PH_FRACN = 3'd3;
  localparam logic [2:0] PH_OFF   = 3'd4;
  localparam logic [2:0] PH_END   = 3'd5;

  // character codes
  localparam logic [7:0] CH_NUL   = 8'h00;
  localparam logic [7:0] CH_DASH  = 8'h2D;
  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_DOT   = 8'h2E;
  localparam logic [7:0] CH_COLON = 8'h3A;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;
  localparam logic [7:0] CH_T_UP  = 8'h54;
  localparam logic [7:0] CH_T_LO  = 8'h74;
  localparam logic [7:0] CH_Z_UP  = 8'h5A;
  localparam logic [7:0] CH_Z_LO  = 8'h7A;

  // character positions inside the date-time and offset fields
  localparam logic [4:0] IDX_DASH1  = 5'd4;
  localparam logic [4:0] IDX_DASH2  = 5'd7;
  localparam logic [4:0] IDX_SEP    = 5'd10;
  localparam logic [4:0] IDX_COLON1 = 5'd13;
  localparam logic [4:0] IDX_COLON2 = 5'd16;
  localparam logic [4:0] IDX_LAST   = 5'd18;
  localparam logic [4:0] IDX_OCOLON = 5'd2;
  localparam logic [4:0] IDX_OLAST  = 5'd4;

  // floor(n / 100) == (n * RECIP100) >> 19 for n below 43699
  localparam logic [12:0] RECIP100   = 13'd5243;
  localparam int          RECIP_SH   = 19;
  // 719468 plus one 400-year cycle, the year is biased by 400
  localparam logic [23:0] DAY_BIAS   = 24'd865565;
  localparam logic [14:0] YEAR_SHIFT = 15'd400;

  typedef struct packed {
    logic        ok;
    logic [13:0] year;
    logic [6:0]  month;
    logic [6:0]  day;
    logic [6:0]  hour;
    logic [6:0]  minute;
    logic [6:0]  second;
    logic [6:0]  off_hour;
    logic [6:0]  off_minute;
    logic        off_neg;
  } rtp_fields_t;

  function automatic logic [6:0] rtp_push2(logic [6:0] acc, logic [3:0] dig);
    logic [10:0] t;
    t = 11'({acc, 3'b000}) + 11'({acc, 1'b0}) + 11'(dig);
    return t[6:0];
  endfunction

  function automatic logic [13:0] rtp_push_year(logic [13:0] acc, logic [3:0] dig);
    logic [17:0] t;
    t = 18'({acc, 3'b000}) + 18'({acc, 1'b0}) + 18'(dig);
    return t[13:0];
  endfunction

  // days from March 1 to the first of the month
  function automatic logic [8:0] rtp_doy_base(logic [6:0] m);
    logic [8:0] r;
    unique case (m)
      7'd1:    r = 9'd306;
      7'd2:    r = 9'd337;
      7'd3:    r = 9'd0;
      7'd4:    r = 9'd31;
      7'd5:    r = 9'd61;
      7'd6:    r = 9'd92;
      7'd7:    r = 9'd122;
      7'd8:    r = 9'd153;
      7'd9:    r = 9'd184;
      7'd10:   r = 9'd214;
      7'd11:   r = 9'd245;
      7'd12:   r = 9'd275;
      default: r = 9'd0;
    endcase
    return r;
  endfunction

  function automatic logic [4:0] rtp_month_len(logic [6:0] m, logic leap);
    logic [4:0] r;
    unique case (m)
      7'd2:                      r = leap ? 5'd29 : 5'd28;
      7'd4, 7'd6, 7'd9, 7'd11:   r = 5'd30;
      default:                   r = 5'd31;
    endcase
    return r;
  endfunction

endpackage

@@ hdl/rfc3339_timestamp_parser.sv @@
// Streaming RFC 3339 timestamp parser with UTC seconds conversion.
//
// Input channel: one ASCII character per word on ch_i (in_valid_i/in_ready_o).
// A NUL word ends the string. Non-NUL words only update the parser state;
// the NUL word produces exactly one result word on the output channel
// (out_valid_o/out_ready_i): valid_res_o and signed UTC seconds_o, which
// are zero when the string is malformed.
// Throughput: one character per cycle while the receiver keeps up,
// including back-to-back strings. The edge that accepts a NUL word
// captures the fields in stage 1; range checks and century quotients
// are registered in stage 2, the day count in stage 3, and the scale
// by 86400 in the output register.
// The conversion pipeline holds up to four finished strings. While the
// receiver stalls, characters keep flowing until all four stages are
// occupied; in_ready_o then stays low for every word, NUL or not, until
// the receiver takes the output word.
// Reset clears the parser to the start of the year field and empties the
// pipeline; the first word after reset starts a new string.
`include "rfc3339_timestamp_parser_defines.svh"

module rfc3339_timestamp_parser (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [7:0]  ch_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic        valid_res_o,
  output logic signed [38:0] seconds_o
);
  import rtp_pkg::*;

  // parser state
  logic [2:0]  phase_q, phase_d;
  logic [4:0]  ci_q, ci_d;
  logic [13:0] year_q, year_d;
  logic [6:0]  month_q, month_d, day_q, day_d, hour_q, hour_d;
  logic [6:0]  minute_q, minute_d, second_q, second_d;
  logic [6:0]  ofh_q, ofh_d, ofm_q, ofm_d;
  logic        neg_q, neg_d, failed_q, failed_d;

  logic in_fire, nul_fire, is_digit, is_zone_z, is_sign;
  logic [3:0] dig;

  // pipeline control
  logic v1_q, v2_q, v3_q, vo_q;
  logic out_free, s3_go, s3_free, s2_go, s2_free, s1_go, s1_free;

  // stage 1: captured fields
  rtp_fields_t s1_q;

  // stage 2
  logic        ok2_q;
  logic [14:0] ybias_q;
  logic [8:0]  qbias_q;
  logic [13:0] year2_q;
  logic [7:0]  qyear2_q;
  logic [6:0]  month2_q, day2_q;
  logic [8:0]  doy2_q;
  logic [18:0] tsec2_q, off2_q;
  logic        neg2_q;

  logic        le_feb, ok2_d;
  logic [14:0] ybias_d;
  logic [27:0] prod_bias;
  logic [26:0] prod_year;
  logic [8:0]  doy2_d;
  logic [18:0] tsec2_d, off2_d;

  // stage 3
  logic               ok3_q;
  logic signed [23:0] days_q;
  logic signed [20:0] net_q;

  logic [13:0] r100;
  logic        leap;
  logic [4:0]  mdays;
  logic        ok3_d;
  logic [23:0] dpos;
  logic signed [23:0] days_d;
  logic signed [20:0] net_d;

  // output
  logic signed [41:0] total;
  logic        res_q;
  logic signed [38:0] sec_q;

  assign out_free = !vo_q || out_ready_i;
  assign s3_go    = v3_q && out_free;
  assign s3_free  = !v3_q || out_free;
  assign s2_go    = v2_q && s3_free;
  assign s2_free  = !v2_q || s3_free;
  assign s1_go    = v1_q && s2_free;
  assign s1_free  = !v1_q || s2_free;

  assign in_ready_o = s1_free;
  assign in_fire    = in_valid_i && in_ready_o;
  assign nul_fire   = in_fire && (ch_i == CH_NUL);

  assign is_digit  = (ch_i >= CH_ZERO) && (ch_i <= CH_NINE);
  assign dig       = ch_i[3:0];
  assign is_zone_z = (ch_i == CH_Z_UP) || (ch_i == CH_Z_LO);
  assign is_sign   = (ch_i == CH_PLUS) || (ch_i == CH_DASH);

  always_comb begin
    phase_d  = phase_q;
    ci_d     = ci_q;
    year_d   = year_q;
    month_d  = month_q;
    day_d    = day_q;
    hour_d   = hour_q;
    minute_d = minute_q;
    second_d = second_q;
    ofh_d    = ofh_q;
    ofm_d    = ofm_q;
    neg_d    = neg_q;
    failed_d = failed_q;
    if (nul_fire) begin
      // back to the start state for the next string
      phase_d  = PH_DATE;
      ci_d     = '0;
      year_d   = '0;
      month_d  = '0;
      day_d    = '0;
      hour_d   = '0;
      minute_d = '0;
      second_d = '0;
      ofh_d    = '0;
      ofm_d    = '0;
      neg_d    = 1'b0;
      failed_d = 1'b0;
    end else if (in_fire && !failed_q) begin
      unique case (phase_q)
        PH_DATE: begin
          priority if (ci_q == IDX_DASH1 || ci_q == IDX_DASH2) begin
            if (ch_i != CH_DASH) failed_d = 1'b1;
          end else if (ci_q == IDX_SEP) begin
            if (ch_i != CH_T_UP && ch_i != CH_T_LO) failed_d = 1'b1;
          end else if (ci_q == IDX_COLON1 || ci_q == IDX_COLON2) begin
            if (ch_i != CH_COLON) failed_d = 1'b1;
          end else if (!is_digit) begin
            failed_d = 1'b1;
          end else if (ci_q < IDX_DASH1) begin
            year_d = rtp_push_year(year_q, dig);
          end else if (ci_q < IDX_DASH2) begin
            month_d = rtp_push2(month_q, dig);
          end else if (ci_q < IDX_SEP) begin
            day_d = rtp_push2(day_q, dig);
          end else if (ci_q < IDX_COLON1) begin
            hour_d = rtp_push2(hour_q, dig);
          end else if (ci_q < IDX_COLON2) begin
            minute_d = rtp_push2(minute_q, dig);
          end else begin
            second_d = rtp_push2(second_q, dig);
          end
          if (!failed_d) begin
            if (ci_q >= IDX_LAST) begin
              phase_d = PH_ZONE;
              ci_d    = '0;
            end else begin
              ci_d = ci_q + 5'd1;
            end
          end
        end
        PH_ZONE: begin
          priority if (ch_i == CH_DOT) begin
            phase_d = PH_FRAC1;
          end else if (is_zone_z) begin
            phase_d = PH_END;
          end else if (is_sign) begin
            neg_d   = (ch_i == CH_DASH);
            phase_d = PH_OFF;
            ci_d    = '0;
          end else begin
            failed_d = 1'b1;
          end
        end
        PH_FRAC1: begin
          if (is_digit) phase_d = PH_FRACN;
          else failed_d = 1'b1;
        end
        PH_FRACN: begin
          priority if (is_digit) begin
            phase_d = PH_FRACN;
          end else if (is_zone_z) begin
            phase_d = PH_END;
          end else if (is_sign) begin
            neg_d   = (ch_i == CH_DASH);
            phase_d = PH_OFF;
            ci_d    = '0;
          end else begin
            failed_d = 1'b1;
          end
        end
        PH_OFF: begin
          priority if (ci_q == IDX_OCOLON) begin
            if (ch_i != CH_COLON) failed_d = 1'b1;
          end else if (!is_digit) begin
            failed_d = 1'b1;
          end else if (ci_q < IDX_OCOLON) begin
            ofh_d = rtp_push2(ofh_q, dig);
          end else begin
            ofm_d = rtp_push2(ofm_q, dig);
          end
          if (!failed_d) begin
            if (ci_q >= IDX_OLAST) begin
              phase_d = PH_END;
              ci_d    = '0;
            end else begin
              ci_d = ci_q + 5'd1;
            end
          end
        end
        default: failed_d = 1'b1;  // trailing characters after the zone
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q  <= PH_DATE;
      ci_q     <= '0;
      year_q   <= '0;
      month_q  <= '0;
      day_q    <= '0;
      hour_q   <= '0;
      minute_q <= '0;
      second_q <= '0;
      ofh_q    <= '0;
      ofm_q    <= '0;
      neg_q    <= 1'b0;
      failed_q <= 1'b0;
    end else begin
      phase_q  <= phase_d;
      ci_q     <= ci_d;
      year_q   <= year_d;
      month_q  <= month_d;
      day_q    <= day_d;
      hour_q   <= hour_d;
      minute_q <= minute_d;
      second_q <= second_d;
      ofh_q    <= ofh_d;
      ofm_q    <= ofm_d;
      neg_q    <= neg_d;
      failed_q <= failed_d;
    end
  end

  // pipeline valid bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      vo_q <= 1'b0;
    end else begin
      if (nul_fire) v1_q <= 1'b1;
      else if (s1_go) v1_q <= 1'b0;
      if (s1_go) v2_q <= 1'b1;
      else if (s2_go) v2_q <= 1'b0;
      if (s2_go) v3_q <= 1'b1;
      else if (s3_go) v3_q <= 1'b0;
      if (s3_go) vo_q <= 1'b1;
      else if (out_ready_i) vo_q <= 1'b0;
    end
  end

  // stage 1: snapshot of the finished string
  always_ff @(posedge clk_i) begin
    if (nul_fire) begin
      s1_q.ok         <= !failed_q && (phase_q == PH_END);
      s1_q.year       <= year_q;
      s1_q.month      <= month_q;
      s1_q.day        <= day_q;
      s1_q.hour       <= hour_q;
      s1_q.minute     <= minute_q;
      s1_q.second     <= second_q;
      s1_q.off_hour   <= ofh_q;
      s1_q.off_minute <= ofm_q;
      s1_q.off_neg    <= neg_q;
    end
  end

  // stage 2: range checks, century quotients, time of day
  always_comb begin
    le_feb    = (s1_q.month <= 7'd2);
    ybias_d   = 15'(s1_q.year) + YEAR_SHIFT - 15'(le_feb);
    prod_bias = 28'(ybias_d) * 28'(RECIP100);
    prod_year = 27'(s1_q.year) * 27'(RECIP100);
    doy2_d    = rtp_doy_base(s1_q.month) + 9'(s1_q.day) - 9'd1;
    tsec2_d   = 19'(s1_q.hour) * 19'd3600 + 19'(s1_q.minute) * 19'd60
              + 19'(s1_q.second);
    off2_d    = 19'(s1_q.off_hour) * 19'd3600 + 19'(s1_q.off_minute) * 19'd60;
    ok2_d     = s1_q.ok && (s1_q.month >= 7'd1) && (s1_q.month <= 7'd12)
              && (s1_q.day >= 7'd1) && (s1_q.hour <= 7'd23)
              && (s1_q.minute <= 7'd59) && (s1_q.second <= 7'd60)
              && (s1_q.off_hour <= 7'd23) && (s1_q.off_minute <= 7'd59);
  end

  always_ff @(posedge clk_i) begin
    if (s1_go) begin
      ok2_q    <= ok2_d;
      ybias_q  <= ybias_d;
      qbias_q  <= prod_bias[27:RECIP_SH];
      year2_q  <= s1_q.year;
      qyear2_q <= prod_year[26:RECIP_SH];
      month2_q <= s1_q.month;
      day2_q   <= s1_q.day;
      doy2_q   <= doy2_d;
      tsec2_q  <= tsec2_d;
      off2_q   <= off2_d;
      neg2_q   <= s1_q.off_neg;
    end
  end

  // stage 3: leap year, day limit, day count since the epoch
  always_comb begin
    r100   = year2_q - 14'(14'(qyear2_q) * 14'd100);
    leap   = ((year2_q[1:0] == 2'b00) && (r100 != '0))
           || ((r100 == '0) && (qyear2_q[1:0] == 2'b00));
    mdays  = rtp_month_len(month2_q, leap);
    ok3_d  = ok2_q && (day2_q <= 7'(mdays));
    dpos   = 24'(ybias_q) * 24'd365 + 24'(ybias_q >> 2) - 24'(qbias_q)
           + 24'(qbias_q >> 2) + 24'(doy2_q);
    days_d = $signed(dpos - DAY_BIAS);
    // a minus offset adds to UTC, a plus offset subtracts
    net_d  = neg2_q ? $signed(21'(tsec2_q) + 21'(off2_q))
                    : $signed(21'(tsec2_q) - 21'(off2_q));
  end

  always_ff @(posedge clk_i) begin
    if (s2_go) begin
      ok3_q  <= ok3_d;
      days_q <= days_d;
      net_q  <= net_d;
    end
  end

  // output stage: scale days to seconds
  assign total = 42'(days_q) * 42'sd86400 + 42'(net_q);

  always_ff @(posedge clk_i) begin
    if (s3_go) begin
      res_q <= ok3_q;
      sec_q <= ok3_q ? total[38:0] : '0;
    end
  end

  assign out_valid_o = vo_q;
  assign valid_res_o = res_q;
  assign seconds_o   = sec_q;

  `RTP_ASSERT_IMP(a_invalid_zero, clk_i, rst_ni, out_valid_o && !valid_res_o, seconds_o == '0)
  `RTP_ASSERT_NXT(a_nul_restart, clk_i, rst_ni, nul_fire, phase_q == PH_DATE && ci_q == '0 && !failed_q)
  `RTP_ASSERT_NXT(a_stage3_hold, clk_i, rst_ni, v3_q && !out_free, v3_q && $stable(days_q))
  `RTP_ASSERT_IMP(a_nul_room, clk_i, rst_ni, nul_fire, !v1_q || s1_go)

endmodule
